>>> design/biquad_iir_filter_assert.svh
// Assertion macros shared by the biquad filter modules.
// No dependencies; included by the controller and the datapath.
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BQF_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BQF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bqf_pkg.sv
// Shared types, register indexes and sequencer command codes of the biquad filter.
// No dependencies; used by every module of the block.
package bqf_pkg;

   // Parameter defaults.
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // Fixed field widths.
   localparam int COEF_W   = 32;
   localparam int GAIN_W   = 31;
   localparam int WET_W    = 17;
   localparam int DELAY_W  = 32;
   localparam int MIX_FRAC = 16;
   localparam int ACC_W    = 66;
   localparam int OPB_W    = 33;

   localparam logic [WET_W-1:0] MIX_ONE = WET_W'(1) << MIX_FRAC;

   // Register file port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type REG_B0   = 3'd0;
   localparam csr_index_type REG_B1   = 3'd1;
   localparam csr_index_type REG_B2   = 3'd2;
   localparam csr_index_type REG_A1   = 3'd3;
   localparam csr_index_type REG_A2   = 3'd4;
   localparam csr_index_type REG_GAIN = 3'd5;
   localparam csr_index_type REG_WET  = 3'd6;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic        [GAIN_W-1:0] gain;
      logic        [WET_W-1:0]  wet;
   } coef_type;

   // Multiplier operand pairs.
   typedef logic [2:0] mul_sel_type;

   localparam mul_sel_type MUL_A1_D1  = 3'd0;
   localparam mul_sel_type MUL_A2_D2  = 3'd1;
   localparam mul_sel_type MUL_B0_W   = 3'd2;
   localparam mul_sel_type MUL_B1_D1  = 3'd3;
   localparam mul_sel_type MUL_B2_D2  = 3'd4;
   localparam mul_sel_type MUL_GAIN_Y = 3'd5;
   localparam mul_sel_type MUL_G_WET  = 3'd6;
   localparam mul_sel_type MUL_X_DRY  = 3'd7;

   // Accumulator operations.
   typedef logic [2:0] acc_op_type;

   localparam acc_op_type ACC_HOLD      = 3'd0;
   localparam acc_op_type ACC_LOAD_W    = 3'd1;
   localparam acc_op_type ACC_LOAD_HALF = 3'd2;
   localparam acc_op_type ACC_LOAD_MIX  = 3'd3;
   localparam acc_op_type ACC_ADD       = 3'd4;
   localparam acc_op_type ACC_SUB       = 3'd5;

   typedef struct packed {
      logic        load_x;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        cap_w;
      logic        cap_y;
      logic        cap_g;
      logic        finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_stall;
   } dp_status_type;

endpackage

>>> design/bqf_regs.sv
// Configuration registers of the biquad filter: coefficients, output gain, wet mix.
// Depends on bqf_pkg.
module bqf_regs #(
   parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  bqf_pkg::csr_index_type           csr_index,
   input  logic [bqf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bqf_pkg::coef_type                cfg
);

   localparam logic [bqf_pkg::COEF_W-1:0] UNITY = bqf_pkg::COEF_W'(1) << COEF_FRAC_BITS;

   bqf_pkg::coef_type cfg_ff;
   bqf_pkg::coef_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bqf_pkg::REG_B0:   cfg_in.b0   = csr_wdata[bqf_pkg::COEF_W-1:0];
            bqf_pkg::REG_B1:   cfg_in.b1   = csr_wdata[bqf_pkg::COEF_W-1:0];
            bqf_pkg::REG_B2:   cfg_in.b2   = csr_wdata[bqf_pkg::COEF_W-1:0];
            bqf_pkg::REG_A1:   cfg_in.a1   = csr_wdata[bqf_pkg::COEF_W-1:0];
            bqf_pkg::REG_A2:   cfg_in.a2   = csr_wdata[bqf_pkg::COEF_W-1:0];
            bqf_pkg::REG_GAIN: cfg_in.gain = csr_wdata[bqf_pkg::GAIN_W-1:0];
            bqf_pkg::REG_WET:  cfg_in.wet  = csr_wdata[bqf_pkg::WET_W-1:0];
            default:           cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.b0   <= UNITY;
         cfg_ff.b1   <= '0;
         cfg_ff.b2   <= '0;
         cfg_ff.a1   <= '0;
         cfg_ff.a2   <= '0;
         cfg_ff.gain <= UNITY[bqf_pkg::GAIN_W-1:0];
         cfg_ff.wet  <= bqf_pkg::MIX_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/bqf_ctrl.sv
// Sequencer of the biquad filter: walks the multiply-accumulate schedule for one item.
// Depends on bqf_pkg and the assertion macro header.
`include "biquad_iir_filter_assert.svh"

module bqf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bqf_pkg::dp_status_type status,
   output bqf_pkg::dp_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Schedule steps; each product is registered and summed at the following step.
   localparam logic [3:0] STEP_A1   = 4'd0;
   localparam logic [3:0] STEP_A2   = 4'd1;
   localparam logic [3:0] STEP_WSUM = 4'd2;
   localparam logic [3:0] STEP_W    = 4'd3;
   localparam logic [3:0] STEP_B2   = 4'd4;
   localparam logic [3:0] STEP_B0   = 4'd5;
   localparam logic [3:0] STEP_YSUM = 4'd6;
   localparam logic [3:0] STEP_Y    = 4'd7;
   localparam logic [3:0] STEP_GAIN = 4'd8;
   localparam logic [3:0] STEP_GSUM = 4'd9;
   localparam logic [3:0] STEP_G    = 4'd10;
   localparam logic [3:0] STEP_WET  = 4'd11;
   localparam logic [3:0] STEP_MSUM = 4'd12;
   localparam logic [3:0] STEP_LAST = 4'd13;

   logic       state_ff, state_in;
   logic [3:0] step_ff, step_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_x = 1'b1;
               state_in   = ST_RUN;
               step_in    = STEP_A1;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               STEP_A1: begin
                  cmd.acc_op  = bqf_pkg::ACC_LOAD_W;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_A1_D1;
               end
               STEP_A2: begin
                  cmd.acc_op  = bqf_pkg::ACC_SUB;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_A2_D2;
               end
               STEP_WSUM: begin
                  cmd.acc_op = bqf_pkg::ACC_SUB;
               end
               STEP_W: begin
                  cmd.cap_w   = 1'b1;
                  cmd.acc_op  = bqf_pkg::ACC_LOAD_HALF;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_B1_D1;
               end
               STEP_B2: begin
                  cmd.acc_op  = bqf_pkg::ACC_ADD;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_B2_D2;
               end
               STEP_B0: begin
                  cmd.acc_op  = bqf_pkg::ACC_ADD;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_B0_W;
               end
               STEP_YSUM: begin
                  cmd.acc_op = bqf_pkg::ACC_ADD;
               end
               STEP_Y: begin
                  cmd.cap_y  = 1'b1;
                  cmd.acc_op = bqf_pkg::ACC_LOAD_HALF;
               end
               STEP_GAIN: begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_GAIN_Y;
               end
               STEP_GSUM: begin
                  cmd.acc_op = bqf_pkg::ACC_ADD;
               end
               STEP_G: begin
                  cmd.cap_g   = 1'b1;
                  cmd.acc_op  = bqf_pkg::ACC_LOAD_MIX;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_X_DRY;
               end
               STEP_WET: begin
                  cmd.acc_op  = bqf_pkg::ACC_ADD;
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = bqf_pkg::MUL_G_WET;
               end
               STEP_MSUM: begin
                  cmd.acc_op = bqf_pkg::ACC_ADD;
               end
               STEP_LAST: begin
                  // Wait here while the previous result is still unread.
                  if (status.out_stall) begin
                     step_in = step_ff;
                  end else begin
                     cmd.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_A1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   `BQF_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == ST_RUN && step_ff == STEP_A1, "accepted item did not start the schedule")
   `BQF_ASSERT_IMPLY(a_step_range, clock, reset, state_ff == ST_RUN, step_ff <= STEP_LAST, "schedule step out of range")
   `BQF_ASSERT_IMPLY(a_no_overwrite, clock, reset, cmd.finish, !status.out_stall, "result written over an unread result")

endmodule

>>> design/bqf_datapath.sv
// Datapath of the biquad filter: shared multiplier, accumulator, delay line and result register.
// Depends on bqf_pkg and the assertion macro header.
`include "biquad_iir_filter_assert.svh"

module bqf_datapath #(
   parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bqf_pkg::coef_type             cfg,
   input  bqf_pkg::dp_cmd_type           cmd,
   output bqf_pkg::dp_status_type        status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic        [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_clipped,
   output logic                          rsp_valid,
   input  logic                          rsp_tready
);

   localparam int ACC_W = bqf_pkg::ACC_W;
   localparam int DW    = bqf_pkg::DELAY_W;
   // The gained value spans the product of a 32-bit value and a 31-bit gain.
   localparam int GW    = 63 - COEF_FRAC_BITS;
   localparam int OPA_W = (GW > 33) ? GW : 33;
   localparam int OPB_W = bqf_pkg::OPB_W;
   localparam int PW    = OPA_W + OPB_W;

   localparam logic signed [ACC_W-1:0] HALF_F   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HALF_MIX = ACC_W'(1) << (bqf_pkg::MIX_FRAC - 1);
   localparam logic signed [ACC_W-1:0] D_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] D_MIN = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] S_MAX =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S_MIN =
      {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [ACC_W-1:0]       prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [DW-1:0]          w_ff, w_in;
   logic signed [DW-1:0]          y_ff, y_in;
   logic signed [GW-1:0]          g_ff, g_in;
   logic signed [DW-1:0]          d1_ff, d1_in;
   logic signed [DW-1:0]          d2_ff, d2_in;
   logic                          clip_ff, clip_in;
   logic        [SAMPLE_BITS-1:0] out_sample_ff, out_sample_in;
   logic                          out_clip_ff, out_clip_in;
   logic                          out_valid_ff, out_valid_in;

   logic [bqf_pkg::WET_W-1:0] wet_eff;
   logic [bqf_pkg::WET_W-1:0] dry;
   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [PW-1:0]      mul_full;
   logic signed [ACC_W-1:0]   shift_f;
   logic signed [ACC_W-1:0]   shift_mix;
   logic signed [DW-1:0]      dsat_val;
   logic                      dsat_flag;
   logic [SAMPLE_BITS-1:0]    mix_val;
   logic                      mix_flag;

   // A wet fraction above one acts as fully filtered.
   always_comb begin
      wet_eff = (cfg.wet > bqf_pkg::MIX_ONE) ? bqf_pkg::MIX_ONE : cfg.wet;
      dry     = bqf_pkg::MIX_ONE - wet_eff;
   end

   always_comb begin
      case (cmd.mul_sel)
         bqf_pkg::MUL_A1_D1: begin
            op_a = OPA_W'(cfg.a1);
            op_b = OPB_W'(d1_ff);
         end
         bqf_pkg::MUL_A2_D2: begin
            op_a = OPA_W'(cfg.a2);
            op_b = OPB_W'(d2_ff);
         end
         bqf_pkg::MUL_B0_W: begin
            op_a = OPA_W'(cfg.b0);
            op_b = OPB_W'(w_ff);
         end
         bqf_pkg::MUL_B1_D1: begin
            op_a = OPA_W'(cfg.b1);
            op_b = OPB_W'(d1_ff);
         end
         bqf_pkg::MUL_B2_D2: begin
            op_a = OPA_W'(cfg.b2);
            op_b = OPB_W'(d2_ff);
         end
         bqf_pkg::MUL_GAIN_Y: begin
            op_a = OPA_W'(y_ff);
            op_b = OPB_W'(cfg.gain);
         end
         bqf_pkg::MUL_G_WET: begin
            op_a = OPA_W'(g_ff);
            op_b = OPB_W'(wet_eff);
         end
         bqf_pkg::MUL_X_DRY: begin
            op_a = OPA_W'(x_ff);
            op_b = OPB_W'(dry);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      mul_full = op_a * op_b;
   end

   // Rounded results: the half LSB is already in the accumulator, so a floor shift remains.
   always_comb begin
      shift_f   = acc_ff >>> COEF_FRAC_BITS;
      shift_mix = acc_ff >>> bqf_pkg::MIX_FRAC;

      dsat_flag = 1'b1;
      if (shift_f > D_MAX) begin
         dsat_val = D_MAX[DW-1:0];
      end else if (shift_f < D_MIN) begin
         dsat_val = D_MIN[DW-1:0];
      end else begin
         dsat_val  = shift_f[DW-1:0];
         dsat_flag = 1'b0;
      end

      mix_flag = 1'b1;
      if (shift_mix > S_MAX) begin
         mix_val = S_MAX[SAMPLE_BITS-1:0];
      end else if (shift_mix < S_MIN) begin
         mix_val = S_MIN[SAMPLE_BITS-1:0];
      end else begin
         mix_val  = shift_mix[SAMPLE_BITS-1:0];
         mix_flag = 1'b0;
      end
   end

   always_comb begin
      x_in    = cmd.load_x ? req_sample : x_ff;
      prod_in = cmd.mul_en ? mul_full[ACC_W-1:0] : prod_ff;

      case (cmd.acc_op)
         bqf_pkg::ACC_HOLD:      acc_in = acc_ff;
         bqf_pkg::ACC_LOAD_W:    acc_in = (ACC_W'(x_ff) <<< COEF_FRAC_BITS) + HALF_F;
         bqf_pkg::ACC_LOAD_HALF: acc_in = HALF_F;
         bqf_pkg::ACC_LOAD_MIX:  acc_in = HALF_MIX;
         bqf_pkg::ACC_ADD:       acc_in = acc_ff + prod_ff;
         bqf_pkg::ACC_SUB:       acc_in = acc_ff - prod_ff;
         default:                acc_in = acc_ff;
      endcase

      clip_in = clip_ff;
      if (cmd.load_x) begin
         clip_in = 1'b0;
      end else if (cmd.cap_w || cmd.cap_y) begin
         clip_in = clip_ff | dsat_flag;
      end

      w_in = cmd.cap_w ? dsat_val : w_ff;
      y_in = cmd.cap_y ? dsat_val : y_ff;
      g_in = cmd.cap_g ? acc_ff[COEF_FRAC_BITS+GW-1:COEF_FRAC_BITS] : g_ff;

      d1_in         = cmd.finish ? w_ff : d1_ff;
      d2_in         = cmd.finish ? d1_ff : d2_ff;
      out_sample_in = cmd.finish ? mix_val : out_sample_ff;
      out_clip_in   = cmd.finish ? (clip_ff | mix_flag) : out_clip_ff;
      out_valid_in  = cmd.finish | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      w_ff          <= w_in;
      y_ff          <= y_in;
      g_ff          <= g_in;
      clip_ff       <= clip_in;
      out_sample_ff <= out_sample_in;
      out_clip_ff   <= out_clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff        <= '0;
         d2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.out_stall = out_valid_ff & ~rsp_tready;
   assign rsp_sample       = out_sample_ff;
   assign rsp_clipped      = out_clip_ff;
   assign rsp_valid        = out_valid_ff;

   `BQF_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, out_valid_ff, "finished item not presented")
   `BQF_ASSERT_NEXT(a_delay_shift, clock, reset, cmd.finish, d1_ff == $past(w_ff) && d2_ff == $past(d1_ff), "delay line not advanced")
   `BQF_ASSERT_NEXT(a_clip_cleared, clock, reset, cmd.load_x, !clip_ff, "saturation flag carried into a new item")

endmodule

>>> design/biquad_iir_filter.sv
// Top level of the biquad IIR filter (direct form II with output gain and dry/wet mix).
// Depends on bqf_pkg, bqf_regs, bqf_ctrl and bqf_datapath.
//
// Usage:
//   The req_ channel carries one signed audio sample per item in req_tdata. The rsp_
//   channel returns exactly one item per input item: the mixed, saturated sample in
//   rsp_tdata and a saturation flag in rsp_tuser. Items are transferred when tvalid
//   and tready are both high at a rising clock edge.
//   The csr_ port writes the five Q4.28 coefficients, the unsigned Q3.28 output gain and the
//   Q1.16 wet fraction; writes take effect at once and should be made while idle.
//   Schedule: an item is accepted while the sequencer is idle, then the sequencer runs
//   fourteen schedule steps through one shared multiplier and one accumulator (eight
//   products, each registered before it is summed). The result is written to the
//   output register as the last step ends, and the next item is taken only after
//   that, so items are processed one at a time through the single multiplier.
//   Stalls: the result sits in an output register. The next item is still accepted
//   and computed while it waits; the block holds in its last step only if that
//   register is still full when the next result is ready.
//   Reset (synchronous, active high) clears the delay values, restores the register
//   defaults (unity b0 and gain, all else zero, fully wet) and empties the output.
module biquad_iir_filter #(
   parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input channel. req_tdata: sample_in in the low SAMPLE_BITS bits, zero padded.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   // Result channel. rsp_tdata: sample_out in the low SAMPLE_BITS bits, zero padded.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   // rsp_tuser: clipped (bit 0).
   output logic                                 rsp_tuser,
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [bqf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bqf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   bqf_pkg::coef_type      cfg;
   bqf_pkg::dp_cmd_type    cmd;
   bqf_pkg::dp_status_type status;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   // Register file: written directly from the configuration port.
   bqf_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: takes an item when idle and steps the datapath through the schedule.
   bqf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: multiplier, accumulator, saturation, delay values and result register.
   bqf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .rsp_sample  (rsp_sample),
      .rsp_clipped (rsp_tuser),
      .rsp_valid   (rsp_tvalid),
      .rsp_tready  (rsp_tready)
   );

   // The sample is carried as raw bits, so the padding above it is zero.
   assign rsp_tdata = TDATA_W'(rsp_sample);

endmodule
